@@ hw/rtl/assert_macros.svh @@
// Assertion macros of the transposer's checker module.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

@@ hw/rtl/mnt_pkg.sv @@
// Shared constants, codes and types of the MIDI note transposer.
// No dependencies; mnt_if, mnt_ctrl, the top level and the checker refer to it.
package mnt_pkg;

    localparam int MAX_HELD = 32;
    localparam int IDX_W    = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
    localparam int COUNT_W  = $clog2(MAX_HELD + 1);

    localparam int OPCODE_W   = 2;
    localparam int CHAN_W     = 4;
    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 7;
    localparam int SEMI_W     = 5;
    localparam int OCT_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    // Wide enough for note + semitones + 12 * octaves at any register value.
    localparam int XP_W       = 10;

    localparam logic [OPCODE_W-1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FLUSH    = 2'd2;

    localparam logic KIND_ON  = 1'b0;
    localparam logic KIND_OFF = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SEMITONE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE   = 2'd1;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [NOTE_W-1:0] in_note;
        logic [NOTE_W-1:0] out_note;
    } held_entry_t;

    localparam int ENTRY_W = $bits(held_entry_t);

    typedef struct packed {
        logic              in_range;
        logic [NOTE_W-1:0] note;
    } xpose_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        held_entry_t      wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

endpackage

@@ hw/rtl/mnt_if.sv @@
// Valid/ready channel interfaces of the transposer: note input, result output
// and register write. Widths come from mnt_pkg.
interface mnt_in_if;
    logic                         valid;
    logic                         ready;
    logic [mnt_pkg::OPCODE_W-1:0] opcode;
    logic [mnt_pkg::CHAN_W-1:0]   channel;
    logic [mnt_pkg::NOTE_W-1:0]   note;
    logic [mnt_pkg::VEL_W-1:0]    velocity;

    modport source (output valid, opcode, channel, note, velocity, input ready);
    modport sink (input valid, opcode, channel, note, velocity, output ready);
endinterface

interface mnt_out_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [mnt_pkg::CHAN_W-1:0] out_channel;
    logic [mnt_pkg::NOTE_W-1:0] out_note;
    logic [mnt_pkg::VEL_W-1:0]  out_velocity;
    logic                       last;

    modport source (output valid, kind, out_channel, out_note, out_velocity, last,
                    input ready);
    modport sink (input valid, kind, out_channel, out_note, out_velocity, last,
                  output ready);
endinterface

interface mnt_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mnt_pkg::CFG_IDX_W-1:0]  index;
    logic [mnt_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/mnt_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mnt_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/mnt_ctrl.sv @@
// Sequencer of the transposer: takes note transactions, searches and edits the
// held-note table in RAM, and drives the registered result channel. Uses mnt_pkg.
module mnt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    mnt_in_if.sink               in_ch,
    mnt_out_if.source            out_ch,
    input  mnt_pkg::xpose_t      xpose,
    input  logic                 offset_wr,
    output mnt_pkg::ram_req_t    ram_req,
    input  mnt_pkg::held_entry_t ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ON,
        S_SEARCH,
        S_MOVE_RD,
        S_MOVE_WR,
        S_EMIT,
        S_FL_RD,
        S_FL_EMIT
    } state_t;

    state_t                         state_reg, state_next;
    logic [mnt_pkg::OPCODE_W-1:0]   op_reg, op_next;
    logic [mnt_pkg::CHAN_W-1:0]     chan_reg, chan_next;
    logic [mnt_pkg::NOTE_W-1:0]     note_reg, note_next;
    logic [mnt_pkg::VEL_W-1:0]      vel_reg, vel_next;
    logic [mnt_pkg::NOTE_W-1:0]     np_reg, np_next;
    logic                           range_reg, range_next;
    logic [mnt_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic                           changed_reg, changed_next;
    logic [mnt_pkg::COUNT_W-1:0]    scan_reg, scan_next;
    logic [mnt_pkg::IDX_W-1:0]      cmp_reg, cmp_next;
    logic                           pend_reg, pend_next;
    logic [mnt_pkg::IDX_W-1:0]      hit_reg, hit_next;
    logic                           rkind_reg, rkind_next;
    logic [mnt_pkg::NOTE_W-1:0]     rnote_reg, rnote_next;
    logic [mnt_pkg::VEL_W-1:0]      rvel_reg, rvel_next;
    logic                           ov_reg, ov_next;
    logic                           okind_reg, okind_next;
    logic [mnt_pkg::CHAN_W-1:0]     ochan_reg, ochan_next;
    logic [mnt_pkg::NOTE_W-1:0]     onote_reg, onote_next;
    logic [mnt_pkg::VEL_W-1:0]      ovel_reg, ovel_next;
    logic                           olast_reg, olast_next;

    logic                           out_free;
    logic                           hit;
    logic                           flush_last;
    logic [mnt_pkg::COUNT_W-1:0]    count_dec;

    assign out_free   = !ov_reg || out_ch.ready;
    assign count_dec  = count_reg - mnt_pkg::COUNT_W'(1);
    assign hit        = pend_reg && (ram_rdata.chan == chan_reg)
                        && (ram_rdata.in_note == note_reg);
    assign flush_last = (scan_reg == count_dec);

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign out_ch.valid        = ov_reg;
    assign out_ch.kind         = okind_reg;
    assign out_ch.out_channel  = ochan_reg;
    assign out_ch.out_note     = onote_reg;
    assign out_ch.out_velocity = ovel_reg;
    assign out_ch.last         = olast_reg;

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        chan_next    = chan_reg;
        note_next    = note_reg;
        vel_next     = vel_reg;
        np_next      = np_reg;
        range_next   = range_reg;
        count_next   = count_reg;
        changed_next = changed_reg || offset_wr;
        scan_next    = scan_reg;
        cmp_next     = cmp_reg;
        pend_next    = pend_reg;
        hit_next     = hit_reg;
        rkind_next   = rkind_reg;
        rnote_next   = rnote_reg;
        rvel_next    = rvel_reg;
        ov_next      = ov_reg && !out_ch.ready;
        okind_next   = okind_reg;
        ochan_next   = ochan_reg;
        onote_next   = onote_reg;
        ovel_next    = ovel_reg;
        olast_next   = olast_reg;
        ram_req      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    op_next    = in_ch.opcode;
                    chan_next  = in_ch.channel;
                    note_next  = in_ch.note;
                    vel_next   = in_ch.velocity;
                    np_next    = xpose.note;
                    range_next = xpose.in_range;
                    scan_next  = '0;
                    pend_next  = 1'b0;
                    case (in_ch.opcode)
                        mnt_pkg::OP_NOTE_ON:
                        begin
                            state_next = S_ON;
                        end
                        mnt_pkg::OP_NOTE_OFF:
                        begin
                            state_next = S_SEARCH;
                        end
                        mnt_pkg::OP_FLUSH:
                        begin
                            if (changed_reg)
                            begin
                                changed_next = 1'b0;
                                if (count_reg != '0)
                                begin
                                    state_next = S_FL_RD;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_ON:
            begin
                rkind_next = mnt_pkg::KIND_ON;
                if (!range_reg)
                begin
                    rnote_next = note_reg;
                    rvel_next  = '0;
                end
                else
                begin
                    rnote_next = np_reg;
                    rvel_next  = vel_reg;
                    if (count_reg < mnt_pkg::COUNT_W'(mnt_pkg::MAX_HELD))
                    begin
                        ram_req.we            = 1'b1;
                        ram_req.waddr         = count_reg[mnt_pkg::IDX_W-1:0];
                        ram_req.wdata.chan    = chan_reg;
                        ram_req.wdata.in_note = note_reg;
                        ram_req.wdata.out_note = np_reg;
                        count_next            = count_reg + mnt_pkg::COUNT_W'(1);
                    end
                end
                state_next = S_EMIT;
            end

            // Reads are issued one per cycle; each read's data is compared in
            // the following cycle while the next read goes out.
            S_SEARCH:
            begin
                rkind_next = mnt_pkg::KIND_OFF;
                rvel_next  = vel_reg;
                if (hit)
                begin
                    rnote_next = ram_rdata.out_note;
                    count_next = count_dec;
                    hit_next   = cmp_reg;
                    pend_next  = 1'b0;
                    if (cmp_reg == count_dec[mnt_pkg::IDX_W-1:0])
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_MOVE_RD;
                    end
                end
                else if (scan_reg < count_reg)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = scan_reg[mnt_pkg::IDX_W-1:0];
                    cmp_next      = scan_reg[mnt_pkg::IDX_W-1:0];
                    pend_next     = 1'b1;
                    scan_next     = scan_reg + mnt_pkg::COUNT_W'(1);
                end
                else
                begin
                    rnote_next = range_reg ? np_reg : note_reg;
                    pend_next  = 1'b0;
                    state_next = S_EMIT;
                end
            end

            // The count was already decremented, so it addresses the last entry.
            S_MOVE_RD:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = count_reg[mnt_pkg::IDX_W-1:0];
                state_next    = S_MOVE_WR;
            end

            S_MOVE_WR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = hit_reg;
                ram_req.wdata = ram_rdata;
                state_next    = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    okind_next = rkind_reg;
                    ochan_next = chan_reg;
                    onote_next = rnote_reg;
                    ovel_next  = rvel_reg;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_FL_RD:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = scan_reg[mnt_pkg::IDX_W-1:0];
                state_next    = S_FL_EMIT;
            end

            S_FL_EMIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    okind_next = mnt_pkg::KIND_OFF;
                    ochan_next = ram_rdata.chan;
                    onote_next = ram_rdata.out_note;
                    ovel_next  = '0;
                    olast_next = flush_last;
                    scan_next  = scan_reg + mnt_pkg::COUNT_W'(1);
                    if (flush_last)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_FL_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            changed_reg <= 1'b0;
            pend_reg    <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            changed_reg <= changed_next;
            pend_reg    <= pend_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        chan_reg  <= chan_next;
        note_reg  <= note_next;
        vel_reg   <= vel_next;
        np_reg    <= np_next;
        range_reg <= range_next;
        scan_reg  <= scan_next;
        cmp_reg   <= cmp_next;
        hit_reg   <= hit_next;
        rkind_reg <= rkind_next;
        rnote_reg <= rnote_next;
        rvel_reg  <= rvel_next;
        okind_reg <= okind_next;
        ochan_reg <= ochan_next;
        onote_reg <= onote_next;
        ovel_reg  <= ovel_next;
        olast_reg <= olast_next;
    end

endmodule

@@ hw/rtl/midi_note_transposer_tracked_top.sv @@
// Top level of the MIDI note transposer with held-note tracking.
// Depends on mnt_pkg, the channel interfaces, mnt_ram and mnt_ctrl.
//
// Usage: note transactions arrive on in_ch (opcode 0 note-on, 1 note-off,
// 2 end of buffer); results leave on out_ch with last marking the final
// result of each input transaction. Register writes on cfg set the semitone
// (index 0) and octave (index 1) offsets; cfg is always ready. cfg is to be
// written only while the block is idle; the block itself does not enforce this.
// in_ch is ready only when the sequencer is idle, so one transaction is
// worked on at a time. A note-on passes S_ON and S_EMIT before its result
// is registered. A note-off searches the held table one RAM read per cycle
// and stops at the first hit; on a hit other than the last entry, the last
// entry is moved into the freed slot. An end-of-buffer flush after an offset
// write sends a note-off for each held entry, reading it in S_FL_RD and
// offering it in S_FL_EMIT, one at a time through the single RAM read port.
// Reset empties the table through its count and clears both offsets; no
// clearing pass is needed. A stalled receiver holds the result register; the
// next input transaction is still taken while a finished result waits.
module midi_note_transposer_tracked_top (
    input  logic      clk,
    input  logic      rst_n,
    mnt_in_if.sink    in_ch,
    mnt_out_if.source out_ch,
    mnt_cfg_if.sink   cfg
);

    logic signed [mnt_pkg::SEMI_W-1:0] semi_reg;
    logic signed [mnt_pkg::OCT_W-1:0]  oct_reg;
    logic signed [mnt_pkg::XP_W-1:0]   semi_ext;
    logic signed [mnt_pkg::XP_W-1:0]   oct_ext;
    logic signed [mnt_pkg::XP_W-1:0]   total;
    logic signed [mnt_pkg::XP_W-1:0]   shifted;
    logic                              offset_wr;
    mnt_pkg::xpose_t                   xpose;
    mnt_pkg::ram_req_t                 ram_req;
    mnt_pkg::held_entry_t              ram_rdata;
    logic [mnt_pkg::ENTRY_W-1:0]       ram_rd_raw;

    assign cfg.ready = 1'b1;
    assign offset_wr = cfg.valid && ((cfg.index == mnt_pkg::CFG_SEMITONE)
                                     || (cfg.index == mnt_pkg::CFG_OCTAVE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            semi_reg <= '0;
            oct_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == mnt_pkg::CFG_SEMITONE)
            begin
                semi_reg <= cfg.data;
            end
            else if (cfg.index == mnt_pkg::CFG_OCTAVE)
            begin
                oct_reg <= cfg.data[mnt_pkg::OCT_W-1:0];
            end
        end
    end

    // Twelve times the octave offset as 8x + 4x.
    assign semi_ext = mnt_pkg::XP_W'(semi_reg);
    assign oct_ext  = mnt_pkg::XP_W'(oct_reg);
    assign total    = semi_ext + (oct_ext <<< 3) + (oct_ext <<< 2);
    assign shifted  = total + signed'(mnt_pkg::XP_W'(in_ch.note));

    assign xpose.in_range = !shifted[mnt_pkg::XP_W-1]
                            && (shifted[mnt_pkg::XP_W-2:mnt_pkg::NOTE_W] == '0);
    assign xpose.note     = shifted[mnt_pkg::NOTE_W-1:0];

    mnt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .xpose     (xpose),
        .offset_wr (offset_wr),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    mnt_ram #(
        .WIDTH (mnt_pkg::ENTRY_W),
        .DEPTH (mnt_pkg::MAX_HELD)
    ) u_held_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rd_raw)
    );

    assign ram_rdata = mnt_pkg::held_entry_t'(ram_rd_raw);

endmodule

@@ hw/rtl/mnt_checker.sv @@
// Port-level checker of the transposer, bound to the top level.
// Depends on mnt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mnt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic [mnt_pkg::OPCODE_W-1:0] in_opcode,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         out_kind,
    input logic [mnt_pkg::CHAN_W-1:0]   out_channel,
    input logic [mnt_pkg::NOTE_W-1:0]   out_note,
    input logic [mnt_pkg::VEL_W-1:0]    out_velocity,
    input logic                         out_last
);

    localparam int PAYLOAD_W = 2 + mnt_pkg::CHAN_W + mnt_pkg::NOTE_W + mnt_pkg::VEL_W;

    logic                 out_stall;
    logic                 on_take;
    logic [PAYLOAD_W-1:0] out_payload;

    assign out_stall   = out_valid && !out_ready;
    assign on_take     = in_valid && in_ready && (in_opcode == mnt_pkg::OP_NOTE_ON);
    assign out_payload = {out_kind, out_channel, out_note, out_velocity, out_last};

    // A stalled result transaction stays offered.
    `ASSERT_NEXT(a_out_hold, out_stall, out_valid)

    // A stalled result transaction keeps its payload.
    `ASSERT_NEXT(a_out_stable, out_stall, $stable(out_payload))

    // Accepting a note-on closes the input.
    `ASSERT_NEXT(a_on_busy, on_take, !in_ready)

    // Note-on results only come from single-result transactions.
    `ASSERT_SAME(a_on_last, out_valid && (out_kind == mnt_pkg::KIND_ON), out_last)

endmodule

bind midi_note_transposer_tracked_top mnt_checker u_mnt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_opcode    (in_ch.opcode),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_kind     (out_ch.kind),
    .out_channel  (out_ch.out_channel),
    .out_note     (out_ch.out_note),
    .out_velocity (out_ch.out_velocity),
    .out_last     (out_ch.last)
);
